[hw/rtl/assert_macros.svh]
// Assertion helpers for the timestamp parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

[hw/rtl/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg
// Types and constants shared by the timestamp parser modules.
// ----------------------------------------------------------------------------
package itp_pkg;
  localparam int unsigned FractionDigits = 9;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [4:0] {
    PH_LEAD, PH_YEAR, PH_DASH1, PH_MONTH, PH_DASH2, PH_DAY, PH_SEP, PH_HOUR,
    PH_COLON, PH_MIN, PH_AFTER_MIN, PH_SEC, PH_AFTER_SEC, PH_FRAC_FIRST,
    PH_FRAC, PH_ZH, PH_ZSEP, PH_ZM_ENTRY, PH_ZM, PH_TRAIL
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_BAD_DATE = 4'd1, ST_NO_TIME = 4'd2, ST_BAD_TIME = 4'd3,
    ST_BAD_SEC = 4'd4, ST_EMPTY_FRAC = 4'd5, ST_BAD_ZONE = 4'd6,
    ST_TRAILING = 4'd7, ST_RANGE = 4'd8
  } status_e;

  // Fields of one finished text, passed from front to back.
  typedef struct packed {
    logic [3:0]  status;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [29:0] frac;
    logic [3:0]  place;
    logic        zneg;
    logic [6:0]  zh;
    logic [6:0]  zm;
  } fields_t;

  // Powers of ten scaling the fraction to nanoseconds.
  function automatic logic [29:0] pow10(input logic [3:0] n);
    unique case (n)
      4'd0: pow10 = 30'd1;
      4'd1: pow10 = 30'd10;
      4'd2: pow10 = 30'd100;
      4'd3: pow10 = 30'd1000;
      4'd4: pow10 = 30'd10000;
      4'd5: pow10 = 30'd100000;
      4'd6: pow10 = 30'd1000000;
      4'd7: pow10 = 30'd10000000;
      4'd8: pow10 = 30'd100000000;
      default: pow10 = 30'd1000000000;
    endcase
  endfunction
endpackage

[hw/rtl/itp_front.sv]
// ----------------------------------------------------------------------------
// itp_front
// Byte-level scanner; emits a field record at each terminator byte.
// ----------------------------------------------------------------------------
module itp_front import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       rec_valid_o,
  output fields_t    rec_o
);
  phase_e      ph_q, ph_d;
  logic [2:0]  dc_q, dc_d;
  logic [13:0] yr_q, yr_d;
  logic [6:0]  mo_q, mo_d, dy_q, dy_d, hr_q, hr_d, mi_q, mi_d, se_q, se_d;
  logic [29:0] fr_q, fr_d;
  logic [3:0]  pl_q, pl_d;
  logic        zn_q, zn_d;
  logic [6:0]  zh_q, zh_d, zm_q, zm_d;
  logic [3:0]  er_q, er_d;
  logic        dig, blank;
  logic [3:0]  dv;
  logic [2:0]  dcn;

  assign dig   = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign blank = (byte_i == 8'h20) || (byte_i == 8'h09);
  assign dv    = byte_i[3:0];
  assign dcn   = dc_q + 3'd1;

  function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
    acc7 = 7'((v * 7'd10) + {3'd0, d});
  endfunction

  always_comb begin
    ph_d = ph_q; dc_d = dc_q; yr_d = yr_q; mo_d = mo_q; dy_d = dy_q;
    hr_d = hr_q; mi_d = mi_q; se_d = se_q; fr_d = fr_q; pl_d = pl_q;
    zn_d = zn_q; zh_d = zh_q; zm_d = zm_q; er_d = er_q;
    if (byte_valid_i && er_q == ST_OK) begin
      unique case (ph_q)
        PH_LEAD, PH_YEAR: begin
          if (ph_q == PH_LEAD && blank) begin
          end else if (!dig) begin
            er_d = ST_BAD_DATE;
            if (ph_q == PH_LEAD) ph_d = PH_YEAR;
          end else begin
            yr_d = 14'((yr_q * 14'd10) + {10'd0, dv});
            if ((ph_q == PH_LEAD ? 3'd1 : dcn) >= 3'd4) begin
              dc_d = '0; ph_d = PH_DASH1;
            end else begin
              dc_d = (ph_q == PH_LEAD) ? 3'd1 : dcn; ph_d = PH_YEAR;
            end
          end
        end
        PH_DASH1: if (byte_i == 8'h2d) ph_d = PH_MONTH; else er_d = ST_BAD_DATE;
        PH_DASH2: if (byte_i == 8'h2d) ph_d = PH_DAY; else er_d = ST_BAD_DATE;
        PH_SEP: begin
          if (byte_i == 8'h54 || byte_i == 8'h20) ph_d = PH_HOUR;
          else er_d = ST_NO_TIME;
        end
        PH_COLON: if (byte_i == 8'h3a) ph_d = PH_MIN; else er_d = ST_BAD_TIME;
        PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_ZH, PH_ZM: begin
          if (!dig) begin
            unique case (ph_q)
              PH_MONTH, PH_DAY: er_d = ST_BAD_DATE;
              PH_HOUR, PH_MIN:  er_d = ST_BAD_TIME;
              PH_SEC:           er_d = ST_BAD_SEC;
              default:          er_d = ST_BAD_ZONE;
            endcase
          end else begin
            unique case (ph_q)
              PH_MONTH: mo_d = acc7(mo_q, dv);
              PH_DAY:   dy_d = acc7(dy_q, dv);
              PH_HOUR:  hr_d = acc7(hr_q, dv);
              PH_MIN:   mi_d = acc7(mi_q, dv);
              PH_SEC:   se_d = acc7(se_q, dv);
              PH_ZH:    zh_d = acc7(zh_q, dv);
              default:  zm_d = acc7(zm_q, dv);
            endcase
            dc_d = dcn;
            if (dcn >= 3'd2) begin
              dc_d = '0;
              unique case (ph_q)
                PH_MONTH: ph_d = PH_DASH2;
                PH_DAY:   ph_d = PH_SEP;
                PH_HOUR:  ph_d = PH_COLON;
                PH_MIN:   ph_d = PH_AFTER_MIN;
                PH_SEC:   ph_d = PH_AFTER_SEC;
                PH_ZH:    ph_d = PH_ZSEP;
                default:  ph_d = PH_TRAIL;
              endcase
            end
          end
        end
        PH_AFTER_MIN, PH_AFTER_SEC, PH_FRAC, PH_FRAC_FIRST: begin
          if (ph_q == PH_AFTER_MIN && byte_i == 8'h3a) begin
            ph_d = PH_SEC; dc_d = '0;
          end else if (ph_q == PH_AFTER_SEC && byte_i == 8'h2e) begin
            ph_d = PH_FRAC_FIRST;
          end else if (ph_q == PH_FRAC_FIRST && !dig) begin
            er_d = ST_EMPTY_FRAC;
          end else if ((ph_q == PH_FRAC || ph_q == PH_FRAC_FIRST) && dig) begin
            ph_d = PH_FRAC;
            if (pl_q < 4'(FractionDigits)) begin
              fr_d = 30'((fr_q * 30'd10) + {26'd0, dv});
              pl_d = pl_q + 4'd1;
            end
          end else if (byte_i == 8'h00) begin
          end else if (byte_i == 8'h5a || byte_i == 8'h7a || blank) begin
            ph_d = PH_TRAIL;
          end else if (byte_i == 8'h2b || byte_i == 8'h2d) begin
            zn_d = (byte_i == 8'h2d); dc_d = '0; ph_d = PH_ZH;
          end else begin
            er_d = ST_TRAILING;
          end
        end
        PH_ZSEP, PH_ZM_ENTRY: begin
          if (byte_i == 8'h00) begin
          end else if (ph_q == PH_ZSEP && byte_i == 8'h3a) begin
            ph_d = PH_ZM_ENTRY;
          end else if (!dig) begin
            ph_d = PH_ZM; dc_d = '0; er_d = ST_BAD_ZONE;
          end else begin
            ph_d = PH_ZM; dc_d = 3'd1; zm_d = acc7(zm_q, dv);
          end
        end
        PH_TRAIL: if (byte_i != 8'h00 && !blank) er_d = ST_TRAILING;
        default: er_d = ST_BAD_DATE;
      endcase
    end
  end

  always_comb begin
    rec_valid_o = byte_valid_i && (byte_i == 8'h00);
    rec_o.status = er_d; rec_o.year = yr_d; rec_o.month = mo_d; rec_o.day = dy_d;
    rec_o.hour = hr_d; rec_o.minute = mi_d; rec_o.second = se_d; rec_o.frac = fr_d;
    rec_o.place = pl_d; rec_o.zneg = zn_d; rec_o.zh = zh_d; rec_o.zm = zm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_LEAD; dc_q <= '0; yr_q <= '0; mo_q <= '0; dy_q <= '0; hr_q <= '0;
      mi_q <= '0; se_q <= '0; fr_q <= '0; pl_q <= '0; zn_q <= 1'b0; zh_q <= '0;
      zm_q <= '0; er_q <= ST_OK;
    end else if (rec_valid_o) begin
      ph_q <= PH_LEAD; dc_q <= '0; yr_q <= '0; mo_q <= '0; dy_q <= '0; hr_q <= '0;
      mi_q <= '0; se_q <= '0; fr_q <= '0; pl_q <= '0; zn_q <= 1'b0; zh_q <= '0;
      zm_q <= '0; er_q <= ST_OK;
    end else begin
      ph_q <= ph_d; dc_q <= dc_d; yr_q <= yr_d; mo_q <= mo_d; dy_q <= dy_d;
      hr_q <= hr_d; mi_q <= mi_d; se_q <= se_d; fr_q <= fr_d; pl_q <= pl_d;
      zn_q <= zn_d; zh_q <= zh_d; zm_q <= zm_d; er_q <= er_d;
    end
  end
endmodule

[hw/rtl/itp_queue.sv]
// ----------------------------------------------------------------------------
// itp_queue
// Two-entry record queue between the scanner and the converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module itp_queue import itp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  fields_t push_data_i,
  output logic    full_o,
  output logic    pop_valid_o,
  input  logic    pop_i,
  output fields_t pop_data_o
);
  fields_t    mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o      = (cnt_q == 2'(QueueDepth));
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, !full_o || pop_i)
  `ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, pop_valid_o)
endmodule

[hw/rtl/itp_back.sv]
// ----------------------------------------------------------------------------
// itp_back
// Three-stage civil-date to Unix-seconds converter with output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module itp_back import itp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  fields_t      in_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [3:0]   status_o,
  output logic [38:0]  secs_o,
  output logic [29:0]  ns_o
);
  // Stage 1: status, era split and day of year.
  logic        v1_q, v2_q, v3_q;
  logic        adv1, adv2, adv3;
  logic [3:0]  st1_q, st2_q, st3_q;
  logic [3:0]  st1_d;
  logic [14:0] yoe1_q;
  logic signed [5:0] era1_q;
  logic [8:0]  doy1_q;
  logic signed [19:0] tod1_q;
  logic [29:0] fr1_q;
  logic [3:0]  pl1_q;
  logic signed [14:0] y;
  logic signed [14:0] era_d;
  logic [8:0]  yoe_d;
  logic [6:0]  mm;
  logic [8:0]  doy_d;
  logic [17:0] tod_pos;
  logic [18:0] off;
  logic signed [19:0] tod_d;

  assign adv3 = !v3_q || out_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_comb begin
    st1_d = in_i.status;
    if (st1_d == ST_OK && (in_i.month < 7'd1 || in_i.month > 7'd12 || in_i.day < 7'd1 ||
        in_i.day > 7'd31 || in_i.hour > 7'd24 || in_i.minute > 7'd59 ||
        in_i.second > 7'd60)) st1_d = ST_RANGE;
    y = $signed({1'b0, in_i.year}) - ((in_i.month <= 7'd2) ? 15'sd1 : 15'sd0);
    // Floor division by 400 via reciprocal; y spans -1..16383.
    era_d = (y < 0) ? -15'sd1 : 15'(({15'd0, y} * 30'd5243) >> 21);
    if (y >= 0 && 15'(era_d * 15'sd400) > y) era_d = era_d - 15'sd1;
    yoe_d = 9'(y - 15'(era_d * 15'sd400));
    mm = (in_i.month > 7'd2) ? in_i.month - 7'd3 : in_i.month + 7'd9;
    doy_d = 9'(((24'(mm) * 24'd153 + 24'd2) * 24'd6554) >> 15) + 9'(in_i.day) - 9'd1;
    tod_pos = 18'(in_i.hour) * 18'd3600 + 18'(in_i.minute) * 18'd60 + 18'(in_i.second);
    // Zone offsets reach 99 hours and 99 minutes, so they need 19 bits.
    off = 19'(in_i.zh) * 19'd3600 + 19'(in_i.zm) * 19'd60;
    tod_d = $signed({2'b00, tod_pos}) + (in_i.zneg ? $signed({1'b0, off})
                                                   : -$signed({1'b0, off}));
  end

  // Stage 2: days since epoch.
  logic signed [23:0] days2_q;
  logic signed [19:0] tod2_q;
  logic [29:0] fr2_q;
  logic [3:0]  pl2_q;
  logic [18:0] doe;
  logic [1:0]  cent;
  always_comb begin
    // Whole centuries in the year of era, which stays below 400.
    cent = (yoe1_q >= 15'd300) ? 2'd3 :
           (yoe1_q >= 15'd200) ? 2'd2 :
           (yoe1_q >= 15'd100) ? 2'd1 : 2'd0;
    doe = 19'(yoe1_q) * 19'd365 + 19'(yoe1_q >> 2) - 19'(cent) + 19'(doy1_q);
  end

  // Stage 3: seconds and nanoseconds.
  logic signed [38:0] secs3_q;
  logic [29:0] ns3_q;

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      st1_q <= st1_d; era1_q <= 6'(era_d); yoe1_q <= 15'(yoe_d); doy1_q <= doy_d;
      tod1_q <= tod_d; fr1_q <= in_i.frac; pl1_q <= in_i.place;
    end
    if (adv2 && v1_q) begin
      st2_q <= st1_q; tod2_q <= tod1_q; fr2_q <= fr1_q; pl2_q <= pl1_q;
      days2_q <= 24'(era1_q) * 24'sd146097 + $signed({5'd0, doe}) - 24'sd719468;
    end
    if (adv3 && v2_q) begin
      st3_q <= st2_q;
      if (st2_q == ST_OK) begin
        secs3_q <= 39'(days2_q) * 39'sd86400 + 39'(tod2_q);
        ns3_q <= 30'(fr2_q * pow10(4'(FractionDigits) - pl2_q));
      end else begin
        secs3_q <= '0; ns3_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign status_o = st3_q;
  assign secs_o = secs3_q;
  assign ns_o = ns3_q;

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(secs_o))
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK, secs_o == '0)
endmodule

[hw/rtl/iso8601_timestamp_parser.sv]
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser
// Streams timestamp text bytes and returns Unix seconds, nanoseconds, status.
// ----------------------------------------------------------------------------
// Usage: send the text one byte per item on text_byte_i with valid/ready.
// A zero byte ends the text and produces exactly one result item on the
// output channel (status_o, unix_seconds_o, fraction_ns_o); other bytes
// produce nothing. One byte is accepted per cycle while the queue is not
// full. The scanner front updates a small state per byte; the record of a
// finished text enters a two-entry queue, and the converter back end turns
// it into seconds in three registered stages. The front stalls only when
// the queue is full, which happens when the receiver holds off results.
// Reset clears the scanner to skip leading blanks, empties the queue and
// drops results in flight.
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser import itp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic signed [38:0] unix_seconds_o,
  output logic [29:0] fraction_ns_o
);
  logic    acc, rec_v, full, qv, pop, bready;
  fields_t rec, qd;
  logic [38:0] secs;

  // Bytes are taken while the queue has room for a possible record.
  assign in_ready_o = !full;
  assign acc = in_valid_i && in_ready_o;

  itp_front u_front (.clk_i, .rst_ni, .byte_valid_i(acc), .byte_i(text_byte_i),
                     .rec_valid_o(rec_v), .rec_o(rec));

  itp_queue u_queue (.clk_i, .rst_ni, .push_i(rec_v), .push_data_i(rec), .full_o(full),
                     .pop_valid_o(qv), .pop_i(pop), .pop_data_o(qd));

  assign pop = qv && bready;

  itp_back u_back (.clk_i, .rst_ni, .in_valid_i(qv), .in_i(qd), .in_ready_o(bready),
                   .out_valid_o, .out_ready_i, .status_o, .secs_o(secs),
                   .ns_o(fraction_ns_o));

  assign unix_seconds_o = $signed(secs);
endmodule

[verif/iso8601_timestamp_parser_checker.sv]
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser_checker
// Watches both channels of the timestamp parser, predicts every result item
// from the accepted text bytes and compares it field by field.
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser_checker import itp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         text_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [3:0]         status_i,
  input  logic signed [38:0] unix_seconds_i,
  input  logic [29:0]        fraction_ns_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  typedef struct packed {
    logic [3:0]         status;
    logic signed [38:0] secs;
    logic [29:0]        ns;
  } stamp_t;

  stamp_t stamp_q[$];

  phase_e      ph;
  int unsigned dcnt, yr, mo, dy, hr, mi, sc, frac, place, zh, zm, err;
  bit          zneg;

  assign pending_o = stamp_q.size();

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == " " || b == 8'h09;
  endfunction

  task automatic clear_scan();
    ph = PH_LEAD;
    {dcnt, yr, mo, dy, hr, mi, sc, frac, place, zh, zm, err} = '0;
    zneg = 1'b0;
  endtask

  // Collects one digit of a fixed-width field.
  task automatic digit(logic [7:0] b, ref int unsigned fld, input int unsigned len,
                       input phase_e nxt, input status_e e);
    if (!is_dig(b)) begin
      err = e;
      return;
    end
    fld = fld * 10 + (b - "0");
    dcnt++;
    if (dcnt >= len) begin
      dcnt = 0;
      ph = nxt;
    end
  endtask

  // What may follow the minutes, the seconds or the fraction.
  task automatic zone_open(logic [7:0] b);
    if (b == 0) return;
    if (b == "Z" || b == "z" || is_blank(b)) ph = PH_TRAIL;
    else if (b == "+" || b == "-") begin
      zneg = (b == "-");
      dcnt = 0;
      ph = PH_ZH;
    end else err = ST_TRAILING;
  endtask

  task automatic scan(logic [7:0] b);
    case (ph)
      PH_LEAD: begin
        if (is_blank(b)) return;
        ph = PH_YEAR;
        dcnt = 0;
        digit(b, yr, 4, PH_DASH1, ST_BAD_DATE);
      end
      PH_YEAR:  digit(b, yr, 4, PH_DASH1, ST_BAD_DATE);
      PH_DASH1: if (b == "-") ph = PH_MONTH; else err = ST_BAD_DATE;
      PH_MONTH: digit(b, mo, 2, PH_DASH2, ST_BAD_DATE);
      PH_DASH2: if (b == "-") ph = PH_DAY; else err = ST_BAD_DATE;
      PH_DAY:   digit(b, dy, 2, PH_SEP, ST_BAD_DATE);
      PH_SEP:   if (b == "T" || b == " ") ph = PH_HOUR; else err = ST_NO_TIME;
      PH_HOUR:  digit(b, hr, 2, PH_COLON, ST_BAD_TIME);
      PH_COLON: if (b == ":") ph = PH_MIN; else err = ST_BAD_TIME;
      PH_MIN:   digit(b, mi, 2, PH_AFTER_MIN, ST_BAD_TIME);
      PH_AFTER_MIN: begin
        if (b == ":") begin
          ph = PH_SEC;
          dcnt = 0;
        end else zone_open(b);
      end
      PH_SEC: digit(b, sc, 2, PH_AFTER_SEC, ST_BAD_SEC);
      PH_AFTER_SEC: if (b == ".") ph = PH_FRAC_FIRST; else zone_open(b);
      PH_FRAC_FIRST, PH_FRAC: begin
        if (is_dig(b)) begin
          ph = PH_FRAC;
          // Digits past the ninth are accepted and dropped.
          if (place < FractionDigits) begin
            frac = frac * 10 + (b - "0");
            place++;
          end
        end else if (ph == PH_FRAC_FIRST) err = ST_EMPTY_FRAC;
        else zone_open(b);
      end
      PH_ZH: digit(b, zh, 2, PH_ZSEP, ST_BAD_ZONE);
      PH_ZSEP, PH_ZM_ENTRY: begin
        if (b == 0) return;
        if (ph == PH_ZSEP && b == ":") ph = PH_ZM_ENTRY;
        else begin
          ph = PH_ZM;
          dcnt = 0;
          digit(b, zm, 2, PH_TRAIL, ST_BAD_ZONE);
        end
      end
      PH_ZM:    digit(b, zm, 2, PH_TRAIL, ST_BAD_ZONE);
      PH_TRAIL: if (b != 0 && !is_blank(b)) err = ST_TRAILING;
      default:  err = ST_BAD_DATE;
    endcase
  endtask

  // Day number since 1970-01-01 in the proleptic Gregorian calendar.
  function automatic longint civil_days(longint y, longint m, longint d);
    longint era, yoe, doy;
    if (m <= 2) y -= 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
  endfunction

  task automatic finish_text();
    stamp_t s;
    longint off, secs;
    longint unsigned ns;
    s = '0;
    s.status = err;
    if (err == 0 && (mo < 1 || mo > 12 || dy < 1 || dy > 31 || hr > 24 ||
                     mi > 59 || sc > 60)) s.status = ST_RANGE;
    if (s.status == ST_OK) begin
      off = longint'(zh) * 3600 + longint'(zm) * 60;
      if (zneg) off = -off;
      secs = civil_days(yr, mo, dy) * 86400 + longint'(hr) * 3600 +
             longint'(mi) * 60 + sc - off;
      ns = frac;
      for (int unsigned p = place; p < 9; p++) ns *= 10;
      s.secs = secs[38:0];
      s.ns = ns[29:0];
    end
    stamp_q = {stamp_q, s};
    clear_scan();
  endtask

  initial begin
    fail_count_o = 0;
    clear_scan();
  end

  always @(posedge clk_i) begin
    stamp_t exp_s;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (stamp_q.size() == 0) begin
          $display("%0t: result item with nothing expected: st=%0d secs=%0d ns=%0d",
                   $time, status_i, unix_seconds_i, fraction_ns_i);
          fail_count_o++;
        end else begin
          exp_s = stamp_q.pop_front();
          if (status_i !== exp_s.status || unix_seconds_i !== exp_s.secs ||
              fraction_ns_i !== exp_s.ns) begin
            $display("%0t: expected st=%0d secs=%0d ns=%0d, actual st=%0d secs=%0d ns=%0d",
                     $time, exp_s.status, exp_s.secs, exp_s.ns, status_i,
                     unix_seconds_i, fraction_ns_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (err == 0) scan(text_byte_i);
        if (text_byte_i == 0) finish_text();
      end
    end
  end
endmodule

[verif/iso8601_timestamp_parser_tb.sv]
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser_tb
// Feeds timestamp texts, directed and random, byte by byte into the parser
// and reports the verdict of the checker that runs beside it.
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser_tb;
  localparam int CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         text_byte_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [3:0]         status_o;
  logic signed [38:0] unix_seconds_o;
  logic [29:0]        fraction_ns_o;
  int                 fail_count, pending;
  int                 cycle_count = 0;
  bit                 hold_results = 1'b0;
  int                 byte_count = 0;

  iso8601_timestamp_parser DUT (.*);

  iso8601_timestamp_parser_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .text_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .unix_seconds_i(unix_seconds_o), .fraction_ns_i(fraction_ns_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls on its own pattern: calm spells, choppy spells, and
  // a long hold-off whenever the stimulus asks for one.
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_results) out_ready_i <= 1'b0;
    else if (cycle_count % 400 < 150) out_ready_i <= 1'b1;
    else out_ready_i <= (r < 60);
  end

  string text_q[$];

  // Sends one byte as an item; valid stays up until the parser takes it.
  // A burst gap is inserted only between items, never while one is pending.
  task automatic send_byte(logic [7:0] b, bit gap);
    if (gap) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    byte_count++;
  endtask

  // Sends a text followed by its terminator. Bursts alternate with gaps.
  task automatic send_text(string s);
    int burst;
    burst = $urandom_range(0, 12);
    for (int i = 0; i <= s.len(); i++) begin
      send_byte(i < s.len() ? s[i] : 8'h00, burst == 0);
      burst = (burst == 0) ? $urandom_range(0, 12) : burst - 1;
    end
  endtask

  function automatic string num(int unsigned v, int w);
    string s;
    s = "";
    for (int i = 0; i < w; i++) begin
      s = {string'(8'("0" + v % 10)), s};
      v /= 10;
    end
    return s;
  endfunction

  // A well-formed text with random content, sometimes bent out of shape.
  function automatic string random_text();
    string s;
    string zs[4];
    int r;
    s = ($urandom_range(0, 3) == 0) ? "  \t" : "";
    s = {s, num($urandom_range(0, 9999), 4), "-", num($urandom_range(0, 13), 2), "-",
         num($urandom_range(0, 32), 2), ($urandom_range(0, 1) ? "T" : " "),
         num($urandom_range(0, 25), 2), ":", num($urandom_range(0, 60), 2)};
    if ($urandom_range(0, 3) != 0) begin
      s = {s, ":", num($urandom_range(0, 61), 2)};
      if ($urandom_range(0, 1)) s = {s, ".", num($urandom, $urandom_range(1, 12))};
    end
    zs[0] = "";
    zs[1] = "Z";
    zs[2] = {($urandom_range(0, 1) ? "+" : "-"), num($urandom_range(0, 99), 2)};
    zs[3] = {zs[2], ($urandom_range(0, 1) ? ":" : ""), num($urandom_range(0, 99), 2)};
    s = {s, zs[$urandom_range(0, 3)]};
    if ($urandom_range(0, 4) == 0) s = {s, " \t "};
    r = $urandom_range(0, 9);
    if (r == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
    else if (r == 1 && s.len() > 0) s[$urandom_range(0, s.len() - 1)] = $urandom_range(1, 255);
    return s;
  endfunction

  function automatic string noise_text();
    string s;
    s = "";
    repeat ($urandom_range(0, 10)) s = {s, string'(8'($urandom_range(1, 255)))};
    return s;
  endfunction

  initial begin
    text_q = '{"1970-01-01T00:00:00Z", "9999-12-31T24:60:60.999999999-99:99",
               "0000-01-01 00:00", "2024-02-29T12:34:56.1234567891234+05:30",
               " \t2000-03-01T01:02:03+0800  ", "2000-13-01T00:00", "2000-00-10T00:00",
               "2000-01-32T00:00", "2000-01-01T00:61", "2000-01-01X00:00", "20x0",
               "2000-01-01T0", "2000-01-01T00:00:5", "2000-01-01T00:00:00.",
               "2000-01-01T00:00+1 ", "2000-01-01T00:00+12:", "2000-01-01T00:00Zq",
               "", "   ", "2000-01-01", "2000-01-01T00:00:00.5z", "1969-12-31T23:59:59-00"};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (text_q[i]) send_text(text_q[i]);
    // Pause the sender until every expected result has come back; the extra
    // edge lets the checker record the last terminator first.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // Hold off results for a long stretch while texts keep coming in.
    fork
      begin
        hold_results = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_results = 1'b0;
      end
      repeat (20) send_text("2001-09-09T01:46:40Z");
    join
    while (byte_count < 1700) begin
      if ($urandom_range(0, 9) == 0) send_text(noise_text());
      else send_text(random_text());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/itp_pkg.sv
hw/rtl/itp_front.sv
hw/rtl/itp_queue.sv
hw/rtl/itp_back.sv
hw/rtl/iso8601_timestamp_parser.sv
verif/iso8601_timestamp_parser_checker.sv
verif/iso8601_timestamp_parser_tb.sv
